// File: src/astc_pkg.sv
package astc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_phase;
    typedef logic [1:0] t_reg_idx;

    // parse phase codes
    localparam t_phase PH_LEN  = 2'd0;
    localparam t_phase PH_TYPE = 2'd1;
    localparam t_phase PH_SKIP = 2'd2;

    // register indexes (byte address / 4)
    localparam t_reg_idx REG_TARGET_TYPE   = 2'd0;
    localparam t_reg_idx REG_TARGET_INDEX  = 2'd1;
    localparam t_reg_idx REG_STOP_ON_MATCH = 2'd2;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // service uuid list type codes
    localparam t_byte AD_UUID16_INC  = 8'h02;
    localparam t_byte AD_UUID16_CMP  = 8'h03;
    localparam t_byte AD_UUID32_INC  = 8'h04;
    localparam t_byte AD_UUID32_CMP  = 8'h05;
    localparam t_byte AD_UUID128_INC = 8'h06;
    localparam t_byte AD_UUID128_CMP = 8'h07;

    localparam t_byte OFFSET_MAX = 8'hFF;

endpackage

// File: src/adv_structure_type_counter_top.sv
// a result beat is offered once its last payload byte has passed the input register
// (the input register takes the byte, the result register is then loaded from it)
// throughput: one payload byte per cycle while the input is not stalled
// the input stalls only while a finished result is still waiting and a last byte is held
// reset is synchronous and active low: it clears the configuration, the walk state and both valids
module adv_structure_type_counter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [astc_pkg::ADDR_W-1:0]   paddr,
    input  logic [astc_pkg::DATA_W-1:0]   pwdata,
    output logic [astc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  astc_pkg::t_byte               i_payload_byte,
    input  astc_pkg::t_byte               i_packet_length,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output astc_pkg::t_byte               o_match_count,
    output astc_pkg::t_byte               o_location,
    output logic                          o_location_valid,
    output logic                          o_stopped_at_index,
    output logic                          o_malformed
);
    import astc_pkg::*;

    // configuration
    t_byte    r_target_type;
    t_byte    r_target_index;
    logic     r_stop_on_match;
    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;

    // input register
    logic     r_in_valid;
    t_byte    r_in_byte;
    t_byte    r_in_plen;
    logic     r_in_last;

    // walk state
    t_byte    r_byte_offset, n_byte_offset;
    t_phase   r_parse_phase, n_parse_phase;
    t_byte    r_structure_start, n_structure_start;
    t_byte    r_structure_left, n_structure_left;
    t_byte    r_running_count, n_running_count;
    t_byte    r_end_offset, n_end_offset;
    logic     r_walk_done, n_walk_done;
    logic     r_overrun_seen, n_overrun_seen;
    logic     r_hit_index, n_hit_index;
    logic     r_empty_pending, n_empty_pending;

    // result register
    logic     r_out_valid;
    t_byte    r_out_count, n_out_count;
    t_byte    r_out_loc, n_out_loc;
    logic     r_out_loc_valid, n_out_loc_valid;
    logic     r_out_stopped, n_out_stopped;
    logic     r_out_malformed, n_out_malformed;

    logic     w_fire;
    logic     w_out_free;

    // match arithmetic, one type check per byte at most
    logic     w_check_en;
    logic     w_match;
    t_byte    w_flen;
    t_byte    w_add;
    t_byte    w_cnt_new;
    logic     w_hit;
    logic [8:0] w_off_plus2;
    logic     w_short;
    logic     w_over;
    logic     w_loc_ok;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            REG_TARGET_TYPE:   prdata = {{(DATA_W-8){1'b0}}, r_target_type};
            REG_TARGET_INDEX:  prdata = {{(DATA_W-8){1'b0}}, r_target_index};
            REG_STOP_ON_MATCH: prdata = {{(DATA_W-1){1'b0}}, r_stop_on_match};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_type   <= '0;
            r_target_index  <= '0;
            r_stop_on_match <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_TARGET_TYPE:   r_target_type   <= pwdata[7:0];
                REG_TARGET_INDEX:  r_target_index  <= pwdata[7:0];
                REG_STOP_ON_MATCH: r_stop_on_match <= pwdata[0];
                default: ;
            endcase
        end
    end

    // a held last byte waits until the result register can take its beat
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_payload_byte;
            r_in_plen <= i_packet_length;
            r_in_last <= i_last_byte;
        end
    end

    always_comb begin
        w_check_en = !r_walk_done
                   && ((r_parse_phase == PH_TYPE)
                       || (r_parse_phase == PH_LEN && r_empty_pending));
        w_match    = (r_in_byte == r_target_type);
        w_flen     = (r_parse_phase == PH_TYPE) ? r_structure_left : 8'd0;
        case (r_in_byte) inside
            AD_UUID16_INC, AD_UUID16_CMP:   w_add = w_flen >> 1;
            AD_UUID32_INC, AD_UUID32_CMP:   w_add = w_flen >> 2;
            AD_UUID128_INC, AD_UUID128_CMP: w_add = w_flen >> 4;
            default:                        w_add = 8'd1;
        endcase
        w_cnt_new   = r_running_count + w_add;
        w_hit       = w_check_en && w_match && r_stop_on_match
                    && ((r_target_index == 8'd0) || (w_cnt_new == r_target_index));
        // fewer than two bytes left, or a length that reaches the end
        w_off_plus2 = {1'b0, r_byte_offset} + 9'd2;
        w_short     = {1'b0, r_in_plen} < w_off_plus2;
        w_over      = ({1'b0, r_in_byte} + {1'b0, r_byte_offset}) >= {1'b0, r_in_plen};
    end

    always_comb begin
        n_byte_offset     = r_byte_offset;
        n_parse_phase     = r_parse_phase;
        n_structure_start = r_structure_start;
        n_structure_left  = r_structure_left;
        n_running_count   = r_running_count;
        n_end_offset      = r_end_offset;
        n_walk_done       = r_walk_done;
        n_overrun_seen    = r_overrun_seen;
        n_hit_index       = r_hit_index;
        n_empty_pending   = r_empty_pending;
        w_loc_ok          = 1'b0;

        if (w_check_en && w_match) begin
            n_running_count = w_cnt_new;
        end
        if (w_hit) begin
            n_walk_done  = 1'b1;
            n_hit_index  = 1'b1;
            n_end_offset = r_structure_start;
        end

        if (!r_walk_done) begin
            case (r_parse_phase)
                PH_TYPE: begin
                    if (!w_hit) begin
                        if (r_structure_left <= 8'd1) begin
                            n_parse_phase = PH_LEN;
                        end else begin
                            n_structure_left = r_structure_left - 8'd1;
                            n_parse_phase    = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_structure_left = r_structure_left - 8'd1;
                    if (r_structure_left == 8'd1) begin
                        n_parse_phase = PH_LEN;
                    end
                end
                default: begin
                    n_parse_phase   = PH_LEN;
                    n_empty_pending = 1'b0;
                    if (!w_hit) begin
                        if (w_short) begin
                            n_walk_done  = 1'b1;
                            n_end_offset = r_byte_offset;
                        end else if (w_over) begin
                            n_walk_done    = 1'b1;
                            n_overrun_seen = 1'b1;
                        end else begin
                            n_structure_start = r_byte_offset;
                            n_structure_left  = r_in_byte;
                            if (r_in_byte == 8'd0) begin
                                n_empty_pending = 1'b1;
                            end else begin
                                n_parse_phase = PH_TYPE;
                            end
                        end
                    end
                end
            endcase
        end

        if (!r_in_last) begin
            if (r_byte_offset != OFFSET_MAX) begin
                n_byte_offset = r_byte_offset + 8'd1;
            end
        end else if (!n_walk_done) begin
            // early last byte: clean end only on a structure boundary
            if (n_parse_phase == PH_LEN && !n_empty_pending) begin
                n_end_offset = (r_byte_offset != OFFSET_MAX) ? r_byte_offset + 8'd1
                                                              : OFFSET_MAX;
            end else begin
                n_overrun_seen = 1'b1;
            end
        end

        w_loc_ok        = !n_overrun_seen && (n_hit_index || (n_end_offset != 8'd0));
        n_out_count     = n_running_count;
        n_out_loc       = w_loc_ok ? n_end_offset : 8'd0;
        n_out_loc_valid = w_loc_ok;
        n_out_stopped   = n_hit_index;
        n_out_malformed = n_overrun_seen;

        if (r_in_last) begin
            n_byte_offset     = '0;
            n_parse_phase     = PH_LEN;
            n_structure_start = '0;
            n_structure_left  = '0;
            n_running_count   = '0;
            n_end_offset      = '0;
            n_walk_done       = 1'b0;
            n_overrun_seen    = 1'b0;
            n_hit_index       = 1'b0;
            n_empty_pending   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset     <= '0;
            r_parse_phase     <= PH_LEN;
            r_structure_start <= '0;
            r_structure_left  <= '0;
            r_running_count   <= '0;
            r_end_offset      <= '0;
            r_walk_done       <= 1'b0;
            r_overrun_seen    <= 1'b0;
            r_hit_index       <= 1'b0;
            r_empty_pending   <= 1'b0;
        end else if (w_fire) begin
            r_byte_offset     <= n_byte_offset;
            r_parse_phase     <= n_parse_phase;
            r_structure_start <= n_structure_start;
            r_structure_left  <= n_structure_left;
            r_running_count   <= n_running_count;
            r_end_offset      <= n_end_offset;
            r_walk_done       <= n_walk_done;
            r_overrun_seen    <= n_overrun_seen;
            r_hit_index       <= n_hit_index;
            r_empty_pending   <= n_empty_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_count     <= n_out_count;
            r_out_loc       <= n_out_loc;
            r_out_loc_valid <= n_out_loc_valid;
            r_out_stopped   <= n_out_stopped;
            r_out_malformed <= n_out_malformed;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_match_count      = r_out_count;
    assign o_location         = r_out_loc;
    assign o_location_valid   = r_out_loc_valid;
    assign o_stopped_at_index = r_out_stopped;
    assign o_malformed        = r_out_malformed;

`ifndef SYNTH
    // a fresh result beat only follows a processed last byte
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (!$past(r_out_valid) || !$past(i_out_stall)))
            |-> $past(w_fire && r_in_last))
        else $error("result beat without a last byte");

    // the packet state is back at its reset values after the last byte
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_fire && r_in_last) |-> (r_byte_offset == 8'd0 && r_parse_phase == PH_LEN
            && !r_walk_done && !r_empty_pending && r_running_count == 8'd0))
        else $error("walk state not cleared after last byte");

    // a stop at the indexed match always carries a location and no overrun
    a_stop_has_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stopped_at_index) |-> (o_location_valid && !o_malformed))
        else $error("stop without location");

    // input stalls only behind a waiting result with a last byte held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without cause");
`endif

endmodule

// File: tb/astc_walk_checker.sv
`timescale 1ns / 1ps

module astc_walk_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [astc_pkg::ADDR_W-1:0] i_paddr,
    input  logic [astc_pkg::DATA_W-1:0] i_pwdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  astc_pkg::t_byte             i_payload_byte,
    input  astc_pkg::t_byte             i_packet_length,
    input  logic                        i_last_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  astc_pkg::t_byte             i_match_count,
    input  astc_pkg::t_byte             i_location,
    input  logic                        i_location_valid,
    input  logic                        i_stopped_at_index,
    input  logic                        i_malformed,
    output int                          o_fail_count,
    output int                          o_waiting,
    output int                          o_checked
);
    import astc_pkg::*;

    typedef struct packed {
        t_byte count;
        t_byte loc;
        logic  loc_ok;
        logic  hit;
        logic  bad;
    } t_packet_summary;

    t_packet_summary pending_summaries[$];
    t_packet_summary want;
    int              fails;
    int              checked;

    // register copies
    t_byte  tgt_type;
    t_byte  tgt_index;
    logic   stop_mode;

    // walk state of the packet in flight
    t_byte  off_q;
    t_phase phase_q;
    t_byte  start_q;
    t_byte  left_q;
    t_byte  count_q;
    t_byte  end_q;
    logic   done_q;
    logic   overrun_q;
    logic   hit_q;
    logic   empty_q;

    task automatic clear_walk();
        off_q     = '0;
        phase_q   = PH_LEN;
        start_q   = '0;
        left_q    = '0;
        count_q   = '0;
        end_q     = '0;
        done_q    = 1'b0;
        overrun_q = 1'b0;
        hit_q     = 1'b0;
        empty_q   = 1'b0;
    endtask

    // uuid lists count their entries, anything else counts once
    function automatic t_byte entries(t_byte ty, t_byte flen);
        case (ty)
            AD_UUID16_INC, AD_UUID16_CMP:   return flen / 8'd2;
            AD_UUID32_INC, AD_UUID32_CMP:   return flen / 8'd4;
            AD_UUID128_INC, AD_UUID128_CMP: return flen / 8'd16;
            default:                        return 8'd1;
        endcase
    endfunction

    task automatic tally(t_byte ty, t_byte flen, t_byte start);
        if (ty != tgt_type) return;
        count_q = count_q + entries(ty, flen);
        if (stop_mode && (tgt_index == 8'd0 || count_q == tgt_index)) begin
            done_q = 1'b1;
            hit_q  = 1'b1;
            end_q  = start;
        end
    endtask

    task automatic walk_byte(t_byte b, t_byte plen, logic last);
        t_byte           o;
        int              rem;
        logic            ok;
        t_packet_summary s;
        o = off_q;
        if (!done_q) begin
            case (phase_q)
                PH_TYPE: begin
                    tally(b, left_q, start_q);
                    if (!done_q) begin
                        if (left_q <= 8'd1) begin
                            phase_q = PH_LEN;
                        end else begin
                            left_q  = left_q - 8'd1;
                            phase_q = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    left_q = left_q - 8'd1;
                    if (left_q == 8'd0) phase_q = PH_LEN;
                end
                default: begin
                    phase_q = PH_LEN;
                    // byte after an empty structure is its type as well as a length
                    if (empty_q) begin
                        empty_q = 1'b0;
                        tally(b, 8'd0, start_q);
                    end
                    if (!done_q) begin
                        rem = int'(plen) - int'(o);
                        if (rem < 2) begin
                            done_q = 1'b1;
                            end_q  = o;
                        end else if (int'(b) >= rem) begin
                            done_q    = 1'b1;
                            overrun_q = 1'b1;
                        end else begin
                            start_q = o;
                            left_q  = b;
                            if (b == 8'd0) empty_q = 1'b1;
                            else phase_q = PH_TYPE;
                        end
                    end
                end
            endcase
        end
        if (!last) begin
            if (off_q != OFFSET_MAX) off_q = off_q + 8'd1;
            return;
        end
        // last byte with the walk still open: clean boundary or truncated structure
        if (!done_q) begin
            done_q = 1'b1;
            if (phase_q == PH_LEN && !empty_q)
                end_q = (o != OFFSET_MAX) ? o + 8'd1 : OFFSET_MAX;
            else overrun_q = 1'b1;
        end
        ok       = !overrun_q && (hit_q || end_q != 8'd0);
        s.count  = count_q;
        s.loc    = ok ? end_q : 8'd0;
        s.loc_ok = ok;
        s.hit    = hit_q;
        s.bad    = overrun_q;
        pending_summaries.push_back(s);
        clear_walk();
    endtask

    task automatic check_field(string what, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tgt_type  = '0;
            tgt_index = '0;
            stop_mode = 1'b0;
            clear_walk();
            pending_summaries.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr >> 2))
                    REG_TARGET_TYPE:   tgt_type  = t_byte'(i_pwdata);
                    REG_TARGET_INDEX:  tgt_index = t_byte'(i_pwdata);
                    REG_STOP_ON_MATCH: stop_mode = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_summaries.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual count %0h loc %0h",
                             $time, i_match_count, i_location);
                    fails++;
                end else begin
                    want = pending_summaries.pop_front();
                    check_field("match_count", int'(want.count), int'(i_match_count));
                    check_field("location", int'(want.loc), int'(i_location));
                    check_field("location_valid", int'(want.loc_ok), int'(i_location_valid));
                    check_field("stopped_at_index", int'(want.hit), int'(i_stopped_at_index));
                    check_field("malformed", int'(want.bad), int'(i_malformed));
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                walk_byte(i_payload_byte, i_packet_length, i_last_byte);
        end
        o_fail_count <= fails;
        o_waiting    <= pending_summaries.size();
        o_checked    <= checked;
    end

endmodule

// File: tb/adv_structure_type_counter_top_tb.sv
`timescale 1ns / 1ps

module adv_structure_type_counter_top_tb;
    import astc_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    t_byte             i_payload_byte;
    t_byte             i_packet_length;
    logic              i_last_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    t_byte             o_match_count;
    t_byte             o_location;
    logic              o_location_valid;
    logic              o_stopped_at_index;
    logic              o_malformed;

    int    fail_count;
    int    waiting;
    int    checked;

    bit    calm;
    bit    tight;
    t_byte cur_type;
    t_byte pkt_bytes[$];
    t_byte pkt_lens[$];
    int    pkt_n;
    int    packets;
    int    sent_bytes;
    int    settings;
    int    rand_bytes;
    int    quota;
    int    phase_no;

    always #4 i_clk = ~i_clk;

    adv_structure_type_counter_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_payload_byte     (i_payload_byte),
        .i_packet_length    (i_packet_length),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_match_count      (o_match_count),
        .o_location         (o_location),
        .o_location_valid   (o_location_valid),
        .o_stopped_at_index (o_stopped_at_index),
        .o_malformed        (o_malformed)
    );

    astc_walk_checker walk_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_payload_byte     (i_payload_byte),
        .i_packet_length    (i_packet_length),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_match_count      (o_match_count),
        .i_location         (o_location),
        .i_location_valid   (o_location_valid),
        .i_stopped_at_index (o_stopped_at_index),
        .i_malformed        (o_malformed),
        .o_fail_count       (fail_count),
        .o_waiting          (waiting),
        .o_checked          (checked)
    );

    // result side back-pressure in bursts, with quiet stretches
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 40) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic reg_write(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // hold the sender until every result is back, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_byte ty, input t_byte idx, input logic stop);
        settle();
        reg_write(REG_TARGET_TYPE, DATA_W'(ty));
        reg_write(REG_TARGET_INDEX, DATA_W'(idx));
        reg_write(REG_STOP_ON_MATCH, DATA_W'(stop));
        cur_type = ty;
        settings++;
    endtask

    task automatic push_byte(input t_byte b, input t_byte plen, input logic last);
        if (!calm && !tight && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_payload_byte  <= b;
        i_packet_length <= plen;
        i_last_byte     <= last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic ship();
        tight = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pkt_n; i++) push_byte(pkt_bytes[i], pkt_lens[i], i == pkt_n - 1);
        packets++;
        sent_bytes += pkt_n;
    endtask

    task automatic set_lengths(input t_byte plen);
        pkt_lens.delete();
        foreach (pkt_bytes[i]) pkt_lens.push_back(plen);
        pkt_n = pkt_bytes.size();
    endtask

    // mostly well-formed structure walks, with truncated, padded, overrun and noise packets
    task automatic build_packet(input int forced_len);
        int    plen;
        int    o;
        int    room;
        int    len;
        int    kind;
        int    r;
        t_byte ty;
        pkt_bytes.delete();
        kind = (forced_len != 0) ? 2 : $urandom_range(0, 19);
        if (forced_len != 0) plen = forced_len;
        else if (kind == 19) plen = $urandom_range(128, 255);
        else if ($urandom_range(0, 9) == 0) plen = $urandom_range(1, 3);
        else plen = $urandom_range(4, 32);
        o = 0;
        while (o < plen) begin
            room = plen - o;
            if (room < 2) begin
                pkt_bytes.push_back(t_byte'($urandom));
                o++;
            end else if (kind >= 16 && $urandom_range(0, 5) == 0) begin
                // length reaching past the packet end
                len = $urandom_range(room, 255);
                pkt_bytes.push_back(t_byte'(len));
                repeat (room - 1) pkt_bytes.push_back(t_byte'($urandom));
                o = plen;
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0) len = 0;
                else if (r == 1) len = $urandom_range(1, room - 1);
                else len = $urandom_range(1, (room - 1 < 6) ? room - 1 : 6);
                case ($urandom_range(0, 4))
                    0, 1:    ty = cur_type;
                    2:       ty = AD_UUID16_INC + t_byte'($urandom_range(0, 5));
                    default: ty = t_byte'($urandom);
                endcase
                pkt_bytes.push_back(t_byte'(len));
                if (len != 0) begin
                    pkt_bytes.push_back(ty);
                    repeat (len - 1) pkt_bytes.push_back(t_byte'($urandom));
                end
                o += len + 1;
            end
        end
        if (kind == 4) begin
            foreach (pkt_bytes[i]) pkt_bytes[i] = t_byte'($urandom);
        end
        if (kind == 2 || kind == 3) begin
            repeat ($urandom_range(1, 4)) pkt_bytes.push_back(t_byte'($urandom));
        end
        set_lengths(t_byte'(plen));
        if (kind == 15) begin
            foreach (pkt_lens[i]) pkt_lens[i] = t_byte'($urandom_range(1, 255));
        end
        if (kind == 19) pkt_n = $urandom_range(2, 24);
        else if (kind <= 1) pkt_n = $urandom_range(1, pkt_bytes.size());
    endtask

    initial begin
        t_byte ty;
        t_byte idx;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_payload_byte  = '0;
        i_packet_length = '0;
        i_last_byte     = 1'b0;
        calm            = 1'b0;
        tight           = 1'b0;
        cur_type        = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apply_settings(AD_UUID16_CMP, 8'h00, 1'b0);
        // short packet: one byte, no location
        pkt_bytes = '{8'hA5};
        set_lengths(8'd1);
        ship();
        // uuid16 list of length four counts two
        pkt_bytes = '{8'h04, 8'h03, 8'h11, 8'h22, 8'h33};
        set_lengths(8'd5);
        ship();
        // length equal to the bytes remaining
        pkt_bytes = '{8'h04, 8'hFF, 8'h00, 8'hFF};
        set_lengths(8'd4);
        ship();
        // empty structure, next byte is both type and length
        pkt_bytes = '{8'h00, 8'h03, 8'h03, 8'h11, 8'h22};
        set_lengths(8'd5);
        ship();
        // last byte inside a structure
        pkt_bytes = '{8'h05, 8'h09};
        set_lengths(8'd255);
        ship();
        // last byte on a structure boundary before the packet end
        pkt_bytes = '{8'h01, 8'h03};
        set_lengths(8'd200);
        ship();
        apply_settings(8'hFF, 8'h00, 1'b1);
        // first match stops the walk, trailing bytes ignored
        pkt_bytes = '{8'h02, 8'hFF, 8'h80, 8'h02, 8'hFF, 8'h7F};
        set_lengths(8'd6);
        ship();

        rand_bytes = 0;
        phase_no   = 0;
        while (rand_bytes < 550) begin
            case (phase_no)
                0: apply_settings(8'hFF, 8'hFF, 1'b1);
                1: apply_settings(8'h00, 8'h00, 1'b0);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       ty = AD_UUID16_INC + t_byte'($urandom_range(0, 5));
                        1:       ty = t_byte'($urandom);
                        default: ty = t_byte'($urandom_range(0, 9));
                    endcase
                    idx = ($urandom_range(0, 3) == 0) ? t_byte'($urandom)
                                                       : t_byte'($urandom_range(0, 5));
                    apply_settings(ty, idx, $urandom_range(0, 2) != 0);
                end
            endcase
            // one over-long packet so the byte offset saturates
            if (phase_no == 3) begin
                build_packet(255);
                ship();
                rand_bytes += pkt_n;
            end
            quota = rand_bytes + 60;
            while (rand_bytes < quota && rand_bytes < 550) begin
                if (rand_bytes >= 480) calm = 1'b1;
                build_packet(0);
                ship();
                rand_bytes += pkt_n;
                if ($urandom_range(0, 11) == 0) settle();
            end
            phase_no++;
        end

        calm = 1'b1;
        settle();
        repeat (8) @(negedge i_clk);
        $display("covered %0d payload bytes in %0d packets under %0d register settings",
                 sent_bytes, packets, settings);
        $display("%0d packet summaries compared, %s", checked,
                 "with short, overrun, empty, truncated and padded packets");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
